// ===== src/priority_ready_queue_with_aging_assert.svh =====
// Assertion macros for the ready queue.
`ifndef PRIORITY_READY_QUEUE_WITH_AGING_ASSERT_SVH
`define PRIORITY_READY_QUEUE_WITH_AGING_ASSERT_SVH

`ifndef SYNTHESIS
`define PRQ_ASSERT_HOLDS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("ready queue check failed");
`define PRQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ready queue sequence check failed");
`else
`define PRQ_ASSERT_HOLDS(lbl, clk, rst, expr)
`define PRQ_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== src/prq_pkg.sv =====
`timescale 1ns / 1ps

package prq_pkg;

   localparam int MAX_PROCS       = 16;
   localparam int LOWEST_PRIORITY = 255;
   localparam int IDX_W           = $clog2(MAX_PROCS);
   localparam int CNT_W           = $clog2(MAX_PROCS + 1);
   localparam int PID_W           = 4;
   localparam int PRIO_W          = 8;
   localparam int CMP_W           = ((IDX_W > PID_W) ? IDX_W : PID_W) + 1;

   localparam logic [PRIO_W-1:0] LOW_PRIO = PRIO_W'(LOWEST_PRIORITY);

   typedef enum logic [1:0] {
      CMD_INSERT,
      CMD_DECREASE,
      CMD_POP,
      CMD_AGE
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_ACTIVE,
      ST_INACTIVE,
      ST_NOCHANGE,
      ST_EMPTY
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic              prio_we;
      logic              act_we;
      logic              act_val;
      logic [PRIO_W-1:0] prio;
   } tbl_wr_type;

endpackage

// ===== src/priority_ready_queue_with_aging.sv =====
`timescale 1ns / 1ps
// Insert and decrease go from idle straight to the finish state; pop and age first
// walk every table entry in the scan state. The result word is registered in finish
// once the output is free. A new word is taken only back in idle, as the one table
// read port and the single comparator are used by the scan entry by entry.
// Reset (synchronous): all pids inactive, priorities lowest, count zero.

`include "priority_ready_queue_with_aging_assert.svh"

module priority_ready_queue_with_aging (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_cmd,
   input  logic [3:0] req_pid,
   input  logic [7:0] req_priority_req,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_status,
   output logic [3:0] rsp_chosen_pid,
   output logic [4:0] rsp_active_count
);

   localparam int IDX_W  = prq_pkg::IDX_W;
   localparam int CNT_W  = prq_pkg::CNT_W;
   localparam int PRIO_W = prq_pkg::PRIO_W;
   localparam int CMP_W  = prq_pkg::CMP_W;

   prq_pkg::state_type state_ff, state_in;
   prq_pkg::cmd_type   cmd_ff, cmd_in;
   logic [3:0]         pid_ff, pid_in;
   logic [PRIO_W-1:0]  preq_ff, preq_in;
   logic [IDX_W-1:0]   scan_ff, scan_in;
   logic [IDX_W-1:0]   best_ff, best_in;
   logic [PRIO_W-1:0]  best_prio_ff, best_prio_in;
   logic               found_ff, found_in;
   logic [CNT_W-1:0]   live_ff, live_in;
   logic               rsp_valid_ff, rsp_valid_in;
   prq_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [3:0]         rsp_chosen_ff, rsp_chosen_in;
   logic [4:0]         rsp_count_ff, rsp_count_in;

   logic                        accept;
   logic                        out_free;
   logic                        pid_in_table;
   logic                        scan_last;
   logic [IDX_W-1:0]            addr;
   logic [PRIO_W-1:0]           rd_prio;
   logic [prq_pkg::MAX_PROCS-1:0] active;
   logic                        act_rd;
   logic [PRIO_W-1:0]           cmp_b;
   logic                        cmp_lt;
   logic [PRIO_W-1:0]           ins_prio;
   prq_pkg::tbl_wr_type         wr;

   assign req_stall    = (state_ff != prq_pkg::S_IDLE);
   assign accept       = req_valid && !req_stall;
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign pid_in_table = CMP_W'(pid_ff) < CMP_W'(prq_pkg::MAX_PROCS);
   assign scan_last    = (scan_ff == IDX_W'(prq_pkg::MAX_PROCS - 1));

   always_comb begin
      case (state_ff)
         prq_pkg::S_FINISH: addr = (cmd_ff == prq_pkg::CMD_POP) ? best_ff : IDX_W'(pid_ff);
         default:           addr = scan_ff;
      endcase
   end

   prq_table u_table (
      .clock   (clock),
      .reset   (reset),
      .idx     (addr),
      .wr      (wr),
      .rd_prio (rd_prio),
      .active  (active)
   );

   assign act_rd = active[addr];

   // shared comparator: running best during pop scan, request on decrease
   assign cmp_b    = (state_ff == prq_pkg::S_SCAN) ? best_prio_ff : preq_ff;
   assign cmp_lt   = rd_prio < cmp_b;
   assign ins_prio = (preq_ff > prq_pkg::LOW_PRIO) ? prq_pkg::LOW_PRIO : preq_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         prq_pkg::S_IDLE: begin
            if (accept) begin
               if (req_cmd == prq_pkg::CMD_POP || req_cmd == prq_pkg::CMD_AGE) begin
                  state_in = prq_pkg::S_SCAN;
               end else begin
                  state_in = prq_pkg::S_FINISH;
               end
            end
         end
         prq_pkg::S_SCAN: begin
            if (scan_last) begin
               state_in = prq_pkg::S_FINISH;
            end
         end
         prq_pkg::S_FINISH: begin
            if (out_free) begin
               state_in = prq_pkg::S_IDLE;
            end
         end
         default: state_in = prq_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd_in        = cmd_ff;
      pid_in        = pid_ff;
      preq_in       = preq_ff;
      scan_in       = scan_ff;
      best_in       = best_ff;
      best_prio_in  = best_prio_ff;
      found_in      = found_ff;
      live_in       = live_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_chosen_in = rsp_chosen_ff;
      rsp_count_in  = rsp_count_ff;
      wr            = '0;
      case (state_ff)
         prq_pkg::S_IDLE: begin
            if (accept) begin
               cmd_in   = prq_pkg::cmd_type'(req_cmd);
               pid_in   = req_pid;
               preq_in  = req_priority_req;
               scan_in  = '0;
               found_in = 1'b0;
            end
         end
         prq_pkg::S_SCAN: begin
            scan_in = scan_ff + IDX_W'(1);
            if (cmd_ff == prq_pkg::CMD_POP) begin
               if (act_rd && (!found_ff || cmp_lt)) begin
                  best_in      = scan_ff;
                  best_prio_in = rd_prio;
                  found_in     = 1'b1;
               end
            end else begin
               if (act_rd && (CMP_W'(scan_ff) != CMP_W'(pid_ff)) && (rd_prio != '0)) begin
                  wr.prio_we = 1'b1;
                  wr.prio    = rd_prio - PRIO_W'(1);
               end
            end
         end
         prq_pkg::S_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_chosen_in = '0;
               rsp_status_in = prq_pkg::ST_OK;
               case (cmd_ff)
                  prq_pkg::CMD_INSERT: begin
                     if (!pid_in_table) begin
                        rsp_status_in = prq_pkg::ST_INACTIVE;
                     end else if (act_rd) begin
                        rsp_status_in = prq_pkg::ST_ACTIVE;
                     end else begin
                        wr.act_we  = 1'b1;
                        wr.act_val = 1'b1;
                        wr.prio_we = 1'b1;
                        wr.prio    = ins_prio;
                        live_in    = live_ff + CNT_W'(1);
                     end
                  end
                  prq_pkg::CMD_DECREASE: begin
                     if (!pid_in_table || !act_rd) begin
                        rsp_status_in = prq_pkg::ST_INACTIVE;
                     end else if (cmp_lt) begin
                        rsp_status_in = prq_pkg::ST_NOCHANGE;
                     end else begin
                        wr.prio_we = 1'b1;
                        wr.prio    = preq_ff;
                     end
                  end
                  prq_pkg::CMD_POP: begin
                     if (!found_ff) begin
                        rsp_status_in = prq_pkg::ST_EMPTY;
                     end else begin
                        rsp_chosen_in = 4'(best_ff);
                        wr.act_we     = 1'b1;
                        wr.act_val    = 1'b0;
                        wr.prio_we    = 1'b1;
                        wr.prio       = prq_pkg::LOW_PRIO;
                        if (live_ff != '0) begin
                           live_in = live_ff - CNT_W'(1);
                        end
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_count_in = 5'(live_in);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prq_pkg::S_IDLE;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
      end
      cmd_ff        <= cmd_in;
      pid_ff        <= pid_in;
      preq_ff       <= preq_in;
      scan_ff       <= scan_in;
      best_ff       <= best_in;
      best_prio_ff  <= best_prio_in;
      rsp_status_ff <= rsp_status_in;
      rsp_chosen_ff <= rsp_chosen_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_chosen_pid   = rsp_chosen_ff;
   assign rsp_active_count = rsp_count_ff;

   `PRQ_ASSERT_HOLDS(a_count_matches, clock, reset, live_ff == CNT_W'($countones(active)))
   `PRQ_ASSERT_NEXT(a_accept_busy, clock, reset, accept, state_ff != prq_pkg::S_IDLE)
   `PRQ_ASSERT_HOLDS(a_chosen_only_on_pop, clock, reset, !rsp_valid_ff || rsp_status_ff == prq_pkg::ST_OK || rsp_chosen_ff == 4'd0)
   `PRQ_ASSERT_NEXT(a_finish_delivers, clock, reset, state_ff == prq_pkg::S_FINISH && out_free, rsp_valid_ff)

endmodule

// ===== src/prq_table.sv =====
`timescale 1ns / 1ps

module prq_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [prq_pkg::IDX_W-1:0]           idx,
   input  prq_pkg::tbl_wr_type                 wr,
   output logic [prq_pkg::PRIO_W-1:0]          rd_prio,
   output logic [prq_pkg::MAX_PROCS-1:0]       active
);

   logic [prq_pkg::PRIO_W-1:0]    prio_ff [prq_pkg::MAX_PROCS];
   logic [prq_pkg::PRIO_W-1:0]    prio_in [prq_pkg::MAX_PROCS];
   logic [prq_pkg::MAX_PROCS-1:0] active_ff;
   logic [prq_pkg::MAX_PROCS-1:0] active_in;

   always_comb begin
      prio_in   = prio_ff;
      active_in = active_ff;
      if (wr.prio_we) begin
         prio_in[idx] = wr.prio;
      end
      if (wr.act_we) begin
         active_in[idx] = wr.act_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < prq_pkg::MAX_PROCS; i++) begin
            prio_ff[i] <= prq_pkg::LOW_PRIO;
         end
         active_ff <= '0;
      end else begin
         prio_ff   <= prio_in;
         active_ff <= active_in;
      end
   end

   assign rd_prio = prio_ff[idx];
   assign active  = active_ff;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

   typedef enum logic [1:0] {
      GAP_NONE,
      GAP_SENDER,
      GAP_RECEIVER,
      GAP_BOTH
   } gap_mode_type;

   typedef struct {
      prq_pkg::cmd_type cmd;
      logic [3:0]       pid;
      logic [7:0]       prio;
   } sched_word_type;

   typedef struct {
      prq_pkg::status_type status;
      logic [3:0]          chosen;
      logic [4:0]          count;
   } sched_result_type;

   localparam int STALL_LIMIT = 4000;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_stall;
   logic [1:0] req_cmd          = '0;
   logic [3:0] req_pid          = '0;
   logic [7:0] req_priority_req = '0;
   logic       rsp_valid;
   logic       rsp_stall        = 1'b0;
   logic [2:0] rsp_status;
   logic [3:0] rsp_chosen_pid;
   logic [4:0] rsp_active_count;

   sched_word_type   word_queue[$];
   sched_result_type expected_results[$];
   gap_mode_type     gap_mode = GAP_NONE;
   int               fail_count = 0;
   int               quiet_cycles = 0;

   // shadow of the ready table
   logic                       is_ready[prq_pkg::MAX_PROCS];
   logic [prq_pkg::PRIO_W-1:0] prio_tab[prq_pkg::MAX_PROCS];
   int                         live_procs;

   priority_ready_queue_with_aging DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_pid          (req_pid),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_chosen_pid   (rsp_chosen_pid),
      .rsp_active_count (rsp_active_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < prq_pkg::MAX_PROCS; i++) begin
         is_ready[i] = 1'b0;
         prio_tab[i] = prq_pkg::LOW_PRIO;
      end
      live_procs = 0;
   end

   function automatic sched_result_type schedule_step(prq_pkg::cmd_type c, logic [3:0] p,
                                                      logic [7:0] pr);
      sched_result_type r;
      int               best;
      logic             in_table;
      logic [7:0]       want_prio;
      r.status  = prq_pkg::ST_OK;
      r.chosen  = '0;
      in_table  = int'(p) < prq_pkg::MAX_PROCS;
      want_prio = (int'(pr) > prq_pkg::LOWEST_PRIORITY) ? prq_pkg::LOW_PRIO : pr;
      case (c)
         prq_pkg::CMD_INSERT: begin
            if (!in_table) begin
               r.status = prq_pkg::ST_INACTIVE;
            end else if (is_ready[p]) begin
               r.status = prq_pkg::ST_ACTIVE;
            end else begin
               is_ready[p] = 1'b1;
               prio_tab[p] = want_prio;
               live_procs++;
            end
         end
         prq_pkg::CMD_DECREASE: begin
            if (!in_table || !is_ready[p]) begin
               r.status = prq_pkg::ST_INACTIVE;
            end else if (prio_tab[p] < pr) begin
               r.status = prq_pkg::ST_NOCHANGE;
            end else begin
               prio_tab[p] = pr;
            end
         end
         prq_pkg::CMD_POP: begin
            best = -1;
            for (int i = 0; i < prq_pkg::MAX_PROCS; i++)
               if (is_ready[i] && (best < 0 || prio_tab[i] < prio_tab[best]))
                  best = i;
            if (best < 0) begin
               r.status = prq_pkg::ST_EMPTY;
            end else begin
               is_ready[best] = 1'b0;
               prio_tab[best] = prq_pkg::LOW_PRIO;
               if (live_procs > 0)
                  live_procs--;
               r.chosen = 4'(best);
            end
         end
         default: begin
            for (int i = 0; i < prq_pkg::MAX_PROCS; i++)
               if (is_ready[i] && i != int'(p) && prio_tab[i] != '0)
                  prio_tab[i] = prio_tab[i] - 1'b1;
         end
      endcase
      r.count = 5'(live_procs);
      return r;
   endfunction

   function automatic logic sender_idles();
      case (gap_mode)
         GAP_SENDER: return $urandom_range(99) < 76;
         GAP_BOTH:   return $urandom_range(99) < 26;
         default:    return 1'b0;
      endcase
   endfunction

   function automatic logic receiver_stalls();
      case (gap_mode)
         GAP_RECEIVER: return $urandom_range(99) < 76;
         GAP_BOTH:     return $urandom_range(99) < 26;
         default:      return 1'b0;
      endcase
   endfunction

   always @(posedge clock) begin : drive_words
      sched_word_type w;
      logic           holding;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         holding = req_valid;
         if (req_valid && !req_stall) begin
            expected_results.push_back(
               schedule_step(prq_pkg::cmd_type'(req_cmd), req_pid, req_priority_req));
            holding = 1'b0;
         end
         if (!holding && word_queue.size() > 0 && !sender_idles()) begin
            w = word_queue.pop_front();
            req_valid        <= 1'b1;
            req_cmd          <= w.cmd;
            req_pid          <= w.pid;
            req_priority_req <= w.prio;
         end else if (!holding) begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= receiver_stalls();
   end

   always @(posedge clock) begin : check_results
      sched_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result word status %0d pid %0d count %0d",
                     $time, rsp_status, rsp_chosen_pid, rsp_active_count);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_status);
               fail_count++;
            end
            if (rsp_chosen_pid !== want.chosen) begin
               $display("%0t: chosen_pid expected %0d actual %0d",
                        $time, want.chosen, rsp_chosen_pid);
               fail_count++;
            end
            if (rsp_active_count !== want.count) begin
               $display("%0t: active_count expected %0d actual %0d",
                        $time, want.count, rsp_active_count);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_word(prq_pkg::cmd_type c, int p, int pr);
      sched_word_type w;
      w.cmd  = c;
      w.pid  = 4'(p);
      w.prio = 8'(pr);
      word_queue.push_back(w);
   endtask

   task automatic push_random_word();
      prq_pkg::cmd_type c;
      int               pick;
      int               pr;
      pick = $urandom_range(99);
      if (pick < 30)
         c = prq_pkg::CMD_INSERT;
      else if (pick < 55)
         c = prq_pkg::CMD_DECREASE;
      else if (pick < 85)
         c = prq_pkg::CMD_POP;
      else
         c = prq_pkg::CMD_AGE;
      case ($urandom_range(7))
         0:       pr = 0;
         1:       pr = 255;
         2:       pr = $urandom_range(3);
         default: pr = $urandom_range(255);
      endcase
      push_word(c, $urandom_range(15), pr);
   endtask

   task automatic drain_words();
      while (word_queue.size() != 0 || req_valid)
         @(negedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // corner sequence, no idling
      push_word(prq_pkg::CMD_POP, 0, 0);
      push_word(prq_pkg::CMD_AGE, 5, 0);
      push_word(prq_pkg::CMD_DECREASE, 3, 10);
      push_word(prq_pkg::CMD_INSERT, 0, 0);
      push_word(prq_pkg::CMD_INSERT, 15, 255);
      push_word(prq_pkg::CMD_INSERT, 0, 7);
      push_word(prq_pkg::CMD_INSERT, 9, 200);
      push_word(prq_pkg::CMD_DECREASE, 9, 201);
      push_word(prq_pkg::CMD_DECREASE, 9, 200);
      push_word(prq_pkg::CMD_DECREASE, 9, 0);
      push_word(prq_pkg::CMD_INSERT, 6, 170);
      push_word(prq_pkg::CMD_INSERT, 5, 85);
      push_word(prq_pkg::CMD_AGE, 15, 0);
      push_word(prq_pkg::CMD_AGE, 0, 0);
      push_word(prq_pkg::CMD_POP, 11, 0);
      push_word(prq_pkg::CMD_POP, 4, 0);
      push_word(prq_pkg::CMD_DECREASE, 15, 254);
      push_word(prq_pkg::CMD_POP, 0, 0);
      push_word(prq_pkg::CMD_POP, 0, 0);
      push_word(prq_pkg::CMD_POP, 0, 0);
      push_word(prq_pkg::CMD_POP, 0, 0);
      push_word(prq_pkg::CMD_INSERT, 10, 1);
      push_word(prq_pkg::CMD_AGE, 10, 0);
      push_word(prq_pkg::CMD_AGE, 3, 0);
      push_word(prq_pkg::CMD_POP, 0, 0);
      drain_words();

      for (int ph = 0; ph < 4; ph++) begin
         gap_mode = gap_mode_type'(ph);
         for (int n = 0; n < 425; n++)
            push_random_word();
         drain_words();
      end

      gap_mode = GAP_NONE;
      while (expected_results.size() != 0)
         @(negedge clock);
      repeat (24) @(negedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== priority_ready_queue_with_aging.f =====
+incdir+src
src/prq_pkg.sv
src/prq_table.sv
src/priority_ready_queue_with_aging.sv
test/tb.sv
